// ----- hdl/lcs_pkg.sv -----
package lcs_pkg;

   // Table geometry and arithmetic widths.
   localparam int MAX_LIGHTS  = 64;
   localparam int WEIGHT_BITS = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int IDX_BITS    = $clog2(MAX_LIGHTS);
   localparam int CNT_BITS    = IDX_BITS + 1;
   localparam int U_BITS      = SAMPLE_BITS + WEIGHT_BITS;
   localparam int STEP_BITS   = $clog2(SAMPLE_BITS);

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_DATA_BITS = 56;
   localparam int RSP_DATA_BITS = 24;

   // Request queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   // Configuration port.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_REG_LIGHT_COUNT = 1'b0;

   typedef enum logic [0:0] {
      KIND_WRITE  = 1'b0,
      KIND_SAMPLE = 1'b1
   } item_kind_type;

   // One classified request as it waits in the queue.
   typedef struct packed {
      item_kind_type            kind;
      logic [IDX_BITS-1:0]      entry_index;
      logic [WEIGHT_BITS-1:0]   entry_weight;
      logic [SAMPLE_BITS-1:0]   uniform_sample;
   } queue_item_type;

   // Access to the weight table.
   typedef struct packed {
      logic                     en;
      logic                     we;
      logic [IDX_BITS-1:0]      addr;
      logic [WEIGHT_BITS-1:0]   wdata;
   } ram_req_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_RD_TOTAL,
      BK_MUL,
      BK_SEARCH,
      BK_CMP,
      BK_RD_PREV,
      BK_RD_CUR,
      BK_SETUP,
      BK_DIV_START,
      BK_DIV,
      BK_RESULT
   } back_state_type;

endpackage

// ----- hdl/lcs_ram.sv -----
module lcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port: write or registered read at one address per cycle.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/lcs_front.sv -----
module lcs_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index [5:0], entry_weight [37:6], uniform_sample [53:38], zero fill
   input  logic [lcs_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // action [0]
   input  logic                              req_tuser,
   output logic                              q_valid,
   output lcs_pkg::queue_item_type           q_item,
   input  logic                              q_pop
);

   lcs_pkg::queue_item_type         slot_ff [lcs_pkg::QUEUE_DEPTH];
   lcs_pkg::queue_item_type         slot_in;
   logic [lcs_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [lcs_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [lcs_pkg::QCNT_BITS-1:0]   fill_ff, fill_in;
   logic                            push;

   // Unpack and classify the incoming request.
   always_comb begin
      slot_in.kind           = lcs_pkg::item_kind_type'(req_tuser);
      slot_in.entry_index    = req_tdata[lcs_pkg::IDX_BITS-1:0];
      slot_in.entry_weight   = req_tdata[6 +: lcs_pkg::WEIGHT_BITS];
      slot_in.uniform_sample = req_tdata[38 +: lcs_pkg::SAMPLE_BITS];
   end

   assign req_tready = (fill_ff != lcs_pkg::QCNT_BITS'(lcs_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != '0);
   assign q_item     = slot_ff[rd_ptr_ff];

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

// ----- hdl/lcs_back.sv -----
module lcs_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [lcs_pkg::CNT_BITS-1:0]      light_count,
   input  logic                              q_valid,
   input  lcs_pkg::queue_item_type           q_item,
   output logic                              q_pop,
   output lcs_pkg::ram_req_type              ram_req,
   input  logic [lcs_pkg::WEIGHT_BITS-1:0]   ram_rdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // light_index [5:0], remapped_sample [21:6], zero fill
   output logic [lcs_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // found [0]
   output logic                              rsp_tuser
);

   localparam int WB = lcs_pkg::WEIGHT_BITS;
   localparam int SB = lcs_pkg::SAMPLE_BITS;
   localparam int UB = lcs_pkg::U_BITS;

   lcs_pkg::back_state_type          state_ff, state_in;
   logic [lcs_pkg::SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic [UB-1:0]                    u_ff, u_in;
   logic [lcs_pkg::CNT_BITS-1:0]     lo_ff, lo_in;
   logic [lcs_pkg::CNT_BITS-1:0]     hi_ff, hi_in;
   logic [lcs_pkg::IDX_BITS-1:0]     mid_ff, mid_in;
   logic [lcs_pkg::IDX_BITS-1:0]     n_ff, n_in;
   logic [WB-1:0]                    prev_ff, prev_in;
   logic [WB-1:0]                    den_ff, den_in;
   logic [UB-1:0]                    num_ff, num_in;
   logic                             zero_ff, zero_in;
   logic [WB-1:0]                    rem_ff, rem_in;
   logic [SB-1:0]                    quo_ff, quo_in;
   logic [lcs_pkg::STEP_BITS-1:0]    step_ff, step_in;
   logic                             found_ff, found_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic [lcs_pkg::IDX_BITS-1:0]     rsp_index_ff, rsp_index_in;
   logic [SB-1:0]                    rsp_remap_ff, rsp_remap_in;

   logic [lcs_pkg::CNT_BITS-1:0]     count;
   logic [lcs_pkg::CNT_BITS:0]       mid_sum;
   logic [UB-1:0]                    prev_scaled;
   logic [WB:0]                      trial;
   logic                             out_free;

   // Effective light count, saturated to the table depth.
   assign count = (light_count > lcs_pkg::CNT_BITS'(lcs_pkg::MAX_LIGHTS))
                ? lcs_pkg::CNT_BITS'(lcs_pkg::MAX_LIGHTS) : light_count;
   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign prev_scaled = {prev_ff, {SB{1'b0}}};
   assign trial       = {rem_ff, quo_ff[SB-1]};
   assign out_free    = !rsp_valid_ff || rsp_tready;

   // Sequencer: table writes, total fetch, binary search, then restoring division.
   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      u_in         = u_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      n_in         = n_ff;
      prev_in      = prev_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      zero_in      = zero_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      rsp_remap_in = rsp_remap_ff;
      q_pop        = 1'b0;
      ram_req      = '0;

      unique case (state_ff)
         lcs_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.kind == lcs_pkg::KIND_WRITE) begin
                  ram_req.en    = 1'b1;
                  ram_req.we    = 1'b1;
                  ram_req.addr  = q_item.entry_index;
                  ram_req.wdata = q_item.entry_weight;
               end else if (count == '0) begin
                  // No lights: an all-zero result.
                  found_in = 1'b0;
                  n_in     = '0;
                  quo_in   = '0;
                  state_in = lcs_pkg::BK_RESULT;
               end else begin
                  found_in  = 1'b1;
                  sample_in = q_item.uniform_sample;
                  state_in  = lcs_pkg::BK_RD_TOTAL;
               end
            end
         end
         lcs_pkg::BK_RD_TOTAL: begin
            ram_req.en   = 1'b1;
            ram_req.addr = lcs_pkg::IDX_BITS'(count - 1'b1);
            state_in     = lcs_pkg::BK_MUL;
         end
         lcs_pkg::BK_MUL: begin
            u_in     = UB'(sample_ff) * UB'(ram_rdata);
            lo_in    = '0;
            hi_in    = count;
            state_in = lcs_pkg::BK_SEARCH;
         end
         lcs_pkg::BK_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mid_in       = lcs_pkg::IDX_BITS'(mid_sum >> 1);
               ram_req.en   = 1'b1;
               ram_req.addr = lcs_pkg::IDX_BITS'(mid_sum >> 1);
               state_in     = lcs_pkg::BK_CMP;
            end else begin
               // No slot above the scaled sample falls back to the last light.
               n_in     = (lo_ff >= count) ? lcs_pkg::IDX_BITS'(count - 1'b1)
                                           : lcs_pkg::IDX_BITS'(lo_ff);
               state_in = lcs_pkg::BK_RD_PREV;
            end
         end
         lcs_pkg::BK_CMP: begin
            if ({ram_rdata, {SB{1'b0}}} > u_ff) begin
               hi_in = {1'b0, mid_ff};
            end else begin
               lo_in = {1'b0, mid_ff} + 1'b1;
            end
            state_in = lcs_pkg::BK_SEARCH;
         end
         lcs_pkg::BK_RD_PREV: begin
            ram_req.en   = 1'b1;
            ram_req.addr = n_ff - 1'b1;
            state_in     = lcs_pkg::BK_RD_CUR;
         end
         lcs_pkg::BK_RD_CUR: begin
            prev_in      = (n_ff == '0) ? '0 : ram_rdata;
            ram_req.en   = 1'b1;
            ram_req.addr = n_ff;
            state_in     = lcs_pkg::BK_SETUP;
         end
         lcs_pkg::BK_SETUP: begin
            den_in   = ram_rdata - prev_ff;
            num_in   = u_ff - prev_scaled;
            zero_in  = (ram_rdata <= prev_ff) || (u_ff < prev_scaled);
            state_in = lcs_pkg::BK_DIV_START;
         end
         lcs_pkg::BK_DIV_START: begin
            if (zero_ff) begin
               quo_in   = '0;
               state_in = lcs_pkg::BK_RESULT;
            end else if (num_ff[UB-1:SB] >= den_ff) begin
               // Quotient does not fit in 16 bits: saturate.
               quo_in   = '1;
               state_in = lcs_pkg::BK_RESULT;
            end else begin
               rem_in   = num_ff[UB-1:SB];
               quo_in   = num_ff[SB-1:0];
               step_in  = '0;
               state_in = lcs_pkg::BK_DIV;
            end
         end
         lcs_pkg::BK_DIV: begin
            // Dividend bits leave the top of quo_ff as quotient bits enter below.
            if (trial >= {1'b0, den_ff}) begin
               rem_in = WB'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[SB-2:0], 1'b1};
            end else begin
               rem_in = WB'(trial);
               quo_in = {quo_ff[SB-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == lcs_pkg::STEP_BITS'(SB - 1)) begin
               state_in = lcs_pkg::BK_RESULT;
            end
         end
         lcs_pkg::BK_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_index_in = n_ff;
               rsp_remap_in = quo_ff;
               state_in     = lcs_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = lcs_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcs_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      u_ff         <= u_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      n_ff         <= n_in;
      prev_ff      <= prev_in;
      den_ff       <= den_in;
      num_ff       <= num_in;
      zero_ff      <= zero_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_remap_ff <= rsp_remap_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{(lcs_pkg::RSP_DATA_BITS - SB - lcs_pkg::IDX_BITS){1'b0}},
                        rsp_remap_ff, rsp_index_ff};

endmodule

// ----- hdl/light_cdf_sampler.sv -----
// Light selection by inverse-CDF lookup over a table of cumulative weights.
// Requests arrive on the req_ stream. tuser low writes one table slot from
// entry_index and entry_weight and gives no response. tuser high draws a
// sample: uniform_sample is scaled by the last valid entry, a binary search
// picks the first slot above it, and the position inside that slot's interval
// is returned as a Q0.16 fraction on the rsp_ stream, with tuser as found.
// The light count register sits at byte address 0 of the csr_ port.
// A table write is done in the cycle the back end takes it from the queue.
// A sample with no lights goes straight to the response; else the back end
// reads the total, runs a binary search (up to seven steps over 64 lights) on
// the single-port table memory, reads the two interval bounds, and runs the
// bit-serial divider for sixteen quotient bits when the remapped fraction
// needs it.
// A two-entry request queue lets new requests be accepted while the back end
// works, and the response register lets the back end go on with writes while
// a response waits for rsp_tready. A stalled receiver holds the response and,
// once the queue is full, req_tready drops.
// Reset clears the light count, the queue and the response valid; the table
// contents are undefined until written.
module light_cdf_sampler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index [5:0], entry_weight [37:6], uniform_sample [53:38], zero fill
   input  logic [lcs_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // action [0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // light_index [5:0], remapped_sample [21:6], zero fill
   output logic [lcs_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // found [0]
   output logic                              rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lcs_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [lcs_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [lcs_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   logic [lcs_pkg::CNT_BITS-1:0]    light_count_ff, light_count_in;
   logic                            csr_write;
   logic                            q_valid;
   logic                            q_pop;
   lcs_pkg::queue_item_type         q_item;
   lcs_pkg::ram_req_type            ram_req;
   logic [lcs_pkg::WEIGHT_BITS-1:0] ram_rdata;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      light_count_in = light_count_ff;
      if (csr_write && (csr_paddr[2] == lcs_pkg::CSR_REG_LIGHT_COUNT)) begin
         light_count_in = csr_pwdata[lcs_pkg::CNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_count_ff <= '0;
      end else begin
         light_count_ff <= light_count_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == lcs_pkg::CSR_REG_LIGHT_COUNT)
                     ? lcs_pkg::CSR_DATA_BITS'(light_count_ff) : '0;

   // Front end: accept and classify requests into the queue.
   lcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // Back end: table access, search and division.
   lcs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .light_count (light_count_ff),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .ram_req     (ram_req),
      .ram_rdata   (ram_rdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // Cumulative weight table.
   lcs_ram #(
      .WIDTH (lcs_pkg::WEIGHT_BITS),
      .DEPTH (lcs_pkg::MAX_LIGHTS)
   ) u_table (
      .clock (clock),
      .en    (ram_req.en),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

`ifndef SYNTHESIS
   // The back end only takes a request that the queue holds.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("queue popped while empty");

   // The table is written only when a write request leaves the queue.
   assert property (@(posedge clock) disable iff (reset) ram_req.we |-> (q_pop && ram_req.en))
      else $error("table written outside a write request");

   // A response without a light carries all-zero data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("empty response with nonzero data");

   // No response is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");
`endif

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_LIGHTS    = lcs_pkg::MAX_LIGHTS;
   localparam int IDX_BITS      = lcs_pkg::IDX_BITS;
   localparam int CNT_BITS      = lcs_pkg::CNT_BITS;
   localparam int WEIGHT_BITS   = lcs_pkg::WEIGHT_BITS;
   localparam int SAMPLE_BITS   = lcs_pkg::SAMPLE_BITS;
   localparam int U_BITS        = lcs_pkg::U_BITS;
   localparam int REQ_DATA_BITS = lcs_pkg::REQ_DATA_BITS;
   localparam int RSP_DATA_BITS = lcs_pkg::RSP_DATA_BITS;
   localparam int CSR_ADDR_BITS = lcs_pkg::CSR_ADDR_BITS;
   localparam int CSR_DATA_BITS = lcs_pkg::CSR_DATA_BITS;

   // One request as the sender sees it, and one light pick as it comes back.
   typedef struct packed {
      lcs_pkg::item_kind_type   kind;
      logic [IDX_BITS-1:0]      slot;
      logic [WEIGHT_BITS-1:0]   weight;
      logic [SAMPLE_BITS-1:0]   uniform;
   } light_req_type;

   typedef struct packed {
      logic                     found;
      logic [IDX_BITS-1:0]      light;
      logic [SAMPLE_BITS-1:0]   remap;
   } light_pick_type;

   localparam logic [CSR_ADDR_BITS-1:0] LIGHT_COUNT_ADDR =
      CSR_ADDR_BITS'({lcs_pkg::CSR_REG_LIGHT_COUNT, 2'b00});
   localparam int IDLE_PERCENT = 14;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     req_tuser = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // Shadow of the block: cumulative weight table and light count register.
   logic [WEIGHT_BITS-1:0]   cdf_table [MAX_LIGHTS];
   logic [CNT_BITS-1:0]      light_count_q = '0;

   light_req_type            pending_reqs [$];
   light_pick_type           expected_picks [$];
   light_req_type            cur_req;
   int unsigned              issued = 0;
   int unsigned              accepted = 0;
   int unsigned              errors = 0;
   int unsigned              n_checked = 0;
   int unsigned              n_writes = 0;
   int unsigned              n_samples = 0;
   int unsigned              n_settings = 0;
   logic                     steady = 1'b0;

   light_cdf_sampler u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Inverse-CDF pick: scale the sample by the total, search for the first
   // slot above it, then place the scaled sample inside that slot's interval.
   function automatic light_pick_type pick_light(input logic [SAMPLE_BITS-1:0] s);
      light_pick_type         r;
      int unsigned            cnt, lo, hi, mid, n;
      logic [U_BITS-1:0]      u, prev_s, quot;
      logic [WEIGHT_BITS-1:0] prev, cur;
      r = '0;
      cnt = (int'(light_count_q) > MAX_LIGHTS) ? MAX_LIGHTS : int'(light_count_q);
      if (cnt == 0)
         return r;
      u = U_BITS'(s) * U_BITS'(cdf_table[cnt-1]);
      lo = 0;
      hi = cnt;
      while (lo < hi) begin
         mid = (lo + hi) >> 1;
         if ({cdf_table[mid], {SAMPLE_BITS{1'b0}}} > u)
            hi = mid;
         else
            lo = mid + 1;
      end
      // A zero total leaves no slot above the sample; fall back to the last.
      n = (lo >= cnt) ? cnt - 1 : lo;
      prev = (n == 0) ? '0 : cdf_table[n-1];
      cur = cdf_table[n];
      prev_s = {prev, {SAMPLE_BITS{1'b0}}};
      r.found = 1'b1;
      r.light = IDX_BITS'(n);
      // Empty intervals and samples below the interval start remap to zero.
      if (cur > prev && u >= prev_s) begin
         quot = (u - prev_s) / U_BITS'(cur - prev);
         r.remap = (quot > U_BITS'(16'hFFFF)) ? 16'hFFFF : quot[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

   // Request driver: holds each request until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (issued == accepted) begin
         if (pending_reqs.size() != 0 &&
             (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            cur_req = pending_reqs.pop_front();
            req_tdata <= REQ_DATA_BITS'({cur_req.uniform, cur_req.weight, cur_req.slot});
            req_tuser <= cur_req.kind;
            req_tvalid <= 1'b1;
            issued++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver stalls at random outside the steady stretch.
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Accepted requests update the shadow table or predict a pick.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         if (cur_req.kind == lcs_pkg::KIND_WRITE)
            cdf_table[cur_req.slot] = cur_req.weight;
         else
            expected_picks = {expected_picks, pick_light(cur_req.uniform)};
         accepted++;
      end
   end

   // Response monitor: compare each pick with the oldest prediction.
   always @(posedge clock) begin
      light_pick_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.found = rsp_tuser;
         got.light = rsp_tdata[IDX_BITS-1:0];
         got.remap = rsp_tdata[IDX_BITS +: SAMPLE_BITS];
         if (expected_picks.size() == 0) begin
            errors++;
            $display("%0t: unexpected response found=%0d light=%0d remap=%0d",
                     $time, got.found, got.light, got.remap);
         end else begin
            want = expected_picks.pop_front();
            if (want != got) begin
               errors++;
               $display({"%0t: mismatch expected found=%0d light=%0d remap=%0d,",
                         " got found=%0d light=%0d remap=%0d"},
                        $time, want.found, want.light, want.remap,
                        got.found, got.light, got.remap);
            end else begin
               n_checked++;
            end
         end
      end
   end

   task automatic push_write(input int unsigned slot, input logic [WEIGHT_BITS-1:0] w);
      light_req_type r;
      r.kind = lcs_pkg::KIND_WRITE;
      r.slot = IDX_BITS'(slot);
      r.weight = w;
      r.uniform = SAMPLE_BITS'($urandom);
      pending_reqs = {pending_reqs, r};
      n_writes++;
   endtask

   task automatic push_sample(input logic [SAMPLE_BITS-1:0] s);
      light_req_type r;
      r.kind = lcs_pkg::KIND_SAMPLE;
      r.slot = IDX_BITS'($urandom);
      r.weight = $urandom;
      r.uniform = s;
      pending_reqs = {pending_reqs, r};
      n_samples++;
   endtask

   // Wait until every request is taken and every pick has come back, then let
   // the back end finish any table write still in flight.
   task automatic wait_idle;
      int unsigned spin;
      spin = 0;
      while ((pending_reqs.size() != 0 || issued != accepted ||
              expected_picks.size() != 0) && spin < 20000) begin
         @(posedge clock);
         spin++;
      end
      repeat (64) @(posedge clock);
   endtask

   // Write the light count register over the CSR port, then read it back.
   task automatic set_light_count(input int unsigned value);
      logic [CSR_DATA_BITS-1:0] rd;
      wait_idle();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= LIGHT_COUNT_ADDR;
      csr_pwdata <= CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      light_count_q = value[CNT_BITS-1:0];
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (rd != CSR_DATA_BITS'(light_count_q)) begin
         errors++;
         $display("%0t: mismatch light count readback expected %0d got %0d",
                  $time, light_count_q, rd);
      end
      n_settings++;
   endtask

   initial begin
      logic [WEIGHT_BITS-1:0] vals [$];
      logic [WEIGHT_BITS-1:0] w;
      int unsigned phase, count, depth, style, sh, nsamp, r;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // No lights: every sample reports nothing found.
      set_light_count(0);
      push_sample(16'h0000);
      push_sample(16'hFFFF);
      // Zero-weight first light, an empty interval, full-scale total, and
      // the outermost slots.
      push_write(0, 32'h0000_0000);
      push_write(1, 32'h0000_0100);
      push_write(2, 32'h0000_0100);
      push_write(3, 32'hFFFF_FFFF);
      push_write(MAX_LIGHTS - 1, 32'hFFFF_FFFF);
      push_write(MAX_LIGHTS - 2, 32'h0000_0000);
      set_light_count(4);
      push_sample(16'h0000);
      push_sample(16'h0001);
      push_sample(16'h8000);
      push_sample(16'hFFFF);
      // Zero total with a single light.
      set_light_count(1);
      push_sample(16'h1234);
      // Non-monotonic table with a zero total: the pick falls back to the
      // last light, below the start of its interval.
      push_write(0, 32'd7);
      push_write(1, 32'd0);
      set_light_count(2);
      push_sample(16'hFFFF);
      // Non-monotonic table with a nonzero total.
      set_light_count(3);
      push_write(0, 32'd1000);
      push_write(1, 32'd10);
      push_write(2, 32'd500);
      push_sample(16'hFFFF);
      push_sample(16'h4000);

      // Random phases: a fresh light count, a full table of that depth, then
      // samples with a little noise from stray table writes.
      phase = 0;
      while (n_writes + n_samples < 1030) begin
         wait_idle();
         steady = (phase >= 10 && phase < 14);
         r = $urandom_range(0, 99);
         if (r < 5)
            count = 0;
         else if (r < 15)
            count = MAX_LIGHTS;
         else if (r == 21)
            count = 127;
         else if (r < 22)
            count = $urandom_range(MAX_LIGHTS + 1, 127);
         else if (r < 40)
            count = $urandom_range(13, MAX_LIGHTS - 1);
         else
            count = $urandom_range(1, 12);
         set_light_count(count);
         depth = (count > MAX_LIGHTS) ? MAX_LIGHTS : count;

         style = $urandom_range(0, 9);
         sh = $urandom_range(0, 31);
         vals.delete();
         for (int k = 0; k < depth; k++) begin
            w = (style == 0) ? '0 : WEIGHT_BITS'($urandom >> sh);
            vals = {vals, w};
         end
         if (style >= 2) begin
            vals.sort();
            if (depth != 0 && $urandom_range(0, 9) == 0)
               vals[depth-1] = 32'hFFFF_FFFF;
         end
         for (int k = 0; k < depth; k++)
            push_write(k, vals[k]);

         nsamp = $urandom_range(8, 30);
         for (int k = 0; k < nsamp; k++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
               push_write($urandom_range(0, MAX_LIGHTS - 1), $urandom);
            else if (r < 13)
               push_sample(16'h0000);
            else if (r < 18)
               push_sample(16'hFFFF);
            else
               push_sample(SAMPLE_BITS'($urandom));
         end
         phase++;
      end

      wait_idle();
      steady = 1'b0;
      if (expected_picks.size() != 0) begin
         errors++;
         $display("%0t: %0d expected responses never arrived", $time,
                  expected_picks.size());
      end
      $display("Covered %0d table writes and %0d samples (%0d picks matched)",
               n_writes, n_samples, n_checked);
      $display("over %0d light count settings from 0 to 127, %0d random phases",
               n_settings, phase);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
